### hw/rtl/slce_pkg.sv
// ----------------------------------------------------------------------------
// Sound log command encoder package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package slce_pkg;

    // Field widths.
    localparam int unsigned VerW   = 2;
    localparam int unsigned PartW  = 7;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 32;
    localparam int unsigned InW    = 56;   // 55 bits of fields, padded to whole bytes

    // Request kinds carried in tuser.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_WAIT  = 1'b1;

    // Command byte constants.
    localparam logic [ByteW-1:0] BYTE_WAIT_ONE  = 8'hff;
    localparam logic [ByteW-1:0] BYTE_WAIT_LONG = 8'hfe;
    localparam logic [ByteW-1:0] VARINT_MORE    = 8'h80;
    localparam logic [6:0]       VARINT_MASK    = 7'h7f;
    localparam logic [CountW-1:0] WAIT_BIAS     = 32'd2;
    localparam logic [VerW-1:0]  VER_SHORT_WAIT = 2'd1;
    localparam logic [VerW-1:0]  VER_RESET      = 2'd3;

    // Byte selector codes from the controller to the datapath.
    localparam logic [2:0] SEL_PART   = 3'd0;
    localparam logic [2:0] SEL_ADDR   = 3'd1;
    localparam logic [2:0] SEL_VAL    = 3'd2;
    localparam logic [2:0] SEL_HDR    = 3'd3;
    localparam logic [2:0] SEL_SHORT  = 3'd4;
    localparam logic [2:0] SEL_VARINT = 3'd5;

    // Controller to datapath commands.
    typedef struct packed {
        logic       load;   // capture the accepted item
        logic       emit;   // write a byte into the output register
        logic [2:0] sel;    // which byte to form
        logic       shift;  // drop the varint digit just sent
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic wait_one;    // the held wait is a single tick
        logic ver_short;   // single-byte wait encoding is selected
        logic var_done;    // no varint digits remain after the current one
    } t_dp_sts;

endpackage

### hw/rtl/slce_ctrl.sv
// ----------------------------------------------------------------------------
// Sound log command encoder controller
// Steps through the bytes of one command and runs the input and output handshakes.
// ----------------------------------------------------------------------------
module slce_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_req_type,
    output logic                 o_in_ready,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    input  slce_pkg::t_dp_sts    i_sts,
    output slce_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PART   = 3'd1;
    localparam logic [2:0] ST_ADDR   = 3'd2;
    localparam logic [2:0] ST_VAL    = 3'd3;
    localparam logic [2:0] ST_HDR    = 3'd4;
    localparam logic [2:0] ST_SHORT  = 3'd5;
    localparam logic [2:0] ST_VARINT = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       slot_free;
    logic       accept;

    // The output register can take a byte when empty or being drained.
    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.load  = accept;
        o_cmd.sel   = slce_pkg::SEL_PART;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_in_req_type == slce_pkg::REQ_WAIT) ? ST_HDR : ST_PART;
                end
            end
            ST_PART: begin
                o_cmd.sel = slce_pkg::SEL_PART;
                if (slot_free) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                o_cmd.sel = slce_pkg::SEL_ADDR;
                if (slot_free) begin
                    n_state = ST_VAL;
                end
            end
            ST_VAL: begin
                o_cmd.sel = slce_pkg::SEL_VAL;
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_HDR: begin
                o_cmd.sel = slce_pkg::SEL_HDR;
                if (slot_free) begin
                    if (i_sts.wait_one) begin
                        n_state = ST_IDLE;
                    end else if (i_sts.ver_short) begin
                        n_state = ST_SHORT;
                    end else begin
                        n_state = ST_VARINT;
                    end
                end
            end
            ST_SHORT: begin
                o_cmd.sel = slce_pkg::SEL_SHORT;
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_VARINT: begin
                o_cmd.sel   = slce_pkg::SEL_VARINT;
                o_cmd.shift = slot_free;
                if (slot_free && i_sts.var_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        o_cmd.emit = (r_state != ST_IDLE) && slot_free;
    end

    // Output valid: set by each new byte, cleared when a transfer drains it.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### hw/rtl/slce_dp.sv
// ----------------------------------------------------------------------------
// Sound log command encoder datapath
// Holds the item, the version register and the output byte register.
// ----------------------------------------------------------------------------
module slce_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [slce_pkg::VerW-1:0]         i_cfg_wr_data,
    input  logic [slce_pkg::InW-1:0]          i_in_data,
    input  slce_pkg::t_dp_cmd                 i_cmd,
    output slce_pkg::t_dp_sts                 o_sts,
    output logic [slce_pkg::ByteW-1:0]        o_out_byte,
    output logic                              o_out_last
);

    logic [slce_pkg::VerW-1:0]   r_version;
    logic [slce_pkg::PartW-1:0]  r_part;
    logic [slce_pkg::ByteW-1:0]  r_addr;
    logic [slce_pkg::ByteW-1:0]  r_val;
    logic [slce_pkg::CountW-1:0] r_cnt;
    logic                        r_wait_one;
    logic [slce_pkg::ByteW-1:0]  r_byte;
    logic                        r_last;
    logic [slce_pkg::ByteW-1:0]  n_byte;
    logic                        n_last;
    logic [slce_pkg::CountW-1:0] in_count;
    logic                        var_done;

    assign in_count = i_in_data[54:23];
    assign var_done = (r_cnt[slce_pkg::CountW-1:7] == '0);

    // Format version register; user must write it in idle, unchecked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= slce_pkg::VER_RESET;
        end else if (i_cfg_wr_en) begin
            r_version <= i_cfg_wr_data;
        end
    end

    // Item capture and varint digit shift.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_part     <= i_in_data[6:0];
            r_addr     <= i_in_data[14:7];
            r_val      <= i_in_data[22:15];
            r_cnt      <= in_count - slce_pkg::WAIT_BIAS;
            r_wait_one <= (in_count == 32'd1);
        end else if (i_cmd.shift) begin
            r_cnt <= r_cnt >> 7;
        end
    end

    // Form the next command byte and its last flag.
    always_comb begin
        n_byte = {1'b0, r_part};
        n_last = 1'b0;
        case (i_cmd.sel)
            slce_pkg::SEL_PART: begin
                n_byte = {1'b0, r_part};
            end
            slce_pkg::SEL_ADDR: begin
                n_byte = r_addr;
            end
            slce_pkg::SEL_VAL: begin
                n_byte = r_val;
                n_last = 1'b1;
            end
            slce_pkg::SEL_HDR: begin
                n_byte = r_wait_one ? slce_pkg::BYTE_WAIT_ONE : slce_pkg::BYTE_WAIT_LONG;
                n_last = r_wait_one;
            end
            slce_pkg::SEL_SHORT: begin
                n_byte = r_cnt[slce_pkg::ByteW-1:0];
                n_last = 1'b1;
            end
            slce_pkg::SEL_VARINT: begin
                n_byte = {1'b0, r_cnt[6:0] & slce_pkg::VARINT_MASK}
                         | (var_done ? 8'h00 : slce_pkg::VARINT_MORE);
                n_last = var_done;
            end
            default: begin
                n_byte = {1'b0, r_part};
                n_last = 1'b0;
            end
        endcase
    end

    // Output byte register; its valid flag lives in the controller.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_byte <= n_byte;
            r_last <= n_last;
        end
    end

    assign o_sts.wait_one  = r_wait_one;
    assign o_sts.ver_short = (r_version == slce_pkg::VER_SHORT_WAIT);
    assign o_sts.var_done  = var_done;
    assign o_out_byte      = r_byte;
    assign o_out_last      = r_last;

endmodule

### hw/rtl/sound_log_command_encoder_unit.sv
// ----------------------------------------------------------------------------
// Sound log command encoder
// Turns register write and wait events into a register-dump byte stream.
// ----------------------------------------------------------------------------
// The first byte of a command goes to the output byte register once the sequencer
//   leaves idle. Throughput: one byte per cycle within a command unless the output
//   stalls; a new item is taken only in idle, after 3 bytes per write or 1 to 6 per wait.
// Reset: synchronous, active low; clears the sequencer and output valid and
//   sets the format version to 3.
module sound_log_command_encoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [slce_pkg::VerW-1:0]     i_cfg_wr_data,  // format_version
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // part_index[6:0], reg_addr[14:7], reg_value[22:15], sync_count[54:23], zero pad
    input  logic [slce_pkg::InW-1:0]      s_axis_tdata,
    input  logic                          s_axis_tuser,   // req_type
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [slce_pkg::ByteW-1:0]    m_axis_tdata,   // out_byte
    output logic                          m_axis_tlast    // last
);

    slce_pkg::t_dp_cmd cmd;
    slce_pkg::t_dp_sts sts;

    // Byte sequencer and output handshake.
    slce_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_req_type (s_axis_tuser),
        .o_in_ready    (s_axis_tready),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    // Item registers and byte formation.
    slce_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (s_axis_tdata),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_byte    (m_axis_tdata),
        .o_out_last    (m_axis_tlast)
    );

    // A new item is never captured while a byte is being formed.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) cmd.load |-> !cmd.emit)
        else $error("item load overlapped a byte emit");

    // The varint digit only shifts out together with its own byte.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.shift |-> (cmd.emit && cmd.sel == slce_pkg::SEL_VARINT))
        else $error("varint shift without a varint byte");

    // After a capture the sequencer is busy on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) cmd.load |=> !s_axis_tready)
        else $error("input ready right after an item capture");

    // Every emitted byte is offered on the output.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) cmd.emit |=> m_axis_tvalid)
        else $error("emitted byte not presented on the output");

endmodule

### tb/sound_log_command_encoder_unit_tb.sv
// ----------------------------------------------------------------------------
// Sound log command encoder testbench
// Drives register write and wait events into the encoder with random gaps on
// both stream sides. A built-in encoder predicts the command bytes of every
// transfer, and each output byte and its last flag are checked in order. The
// format version goes through every setting, changed only while idle.
// ----------------------------------------------------------------------------
module sound_log_command_encoder_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // One logged event as it enters the encoder.
    typedef struct {
        logic                        kind;
        logic [slce_pkg::PartW-1:0]  part;
        logic [slce_pkg::ByteW-1:0]  addr;
        logic [slce_pkg::ByteW-1:0]  val;
        logic [slce_pkg::CountW-1:0] count;
    } t_log_item;

    // One byte of the encoded command stream.
    typedef struct {
        logic [slce_pkg::ByteW-1:0] data;
        logic                       last;
    } t_cmd_byte;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_wr_en   = 1'b0;
    logic [slce_pkg::VerW-1:0]     i_cfg_wr_data = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [slce_pkg::InW-1:0]      s_axis_tdata  = '0;
    logic                          s_axis_tuser  = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [slce_pkg::ByteW-1:0]    m_axis_tdata;
    logic                          m_axis_tlast;

    t_log_item   log_items_q[$];
    t_cmd_byte   cmd_bytes_q[$];
    t_log_item   sent_item;
    logic [slce_pkg::VerW-1:0] fmt_version = slce_pkg::VER_RESET;
    int unsigned fail_cnt = 0;
    int unsigned send_gap = 0;
    int unsigned send_quiet = 0;
    int unsigned recv_stall = 0;
    int unsigned recv_quiet = 0;

    sound_log_command_encoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 40) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(3, 1);
        end else if (r < 97) begin
            return $urandom_range(10, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    // Append the command bytes that one event turns into.
    function automatic void encode_command(t_log_item it);
        logic [slce_pkg::CountW-1:0] rest;
        logic [6:0]                  digit;
        bit                          done;
        if (it.kind == slce_pkg::REQ_WRITE) begin
            cmd_bytes_q.push_back('{{1'b0, it.part}, 1'b0});
            cmd_bytes_q.push_back('{it.addr, 1'b0});
            cmd_bytes_q.push_back('{it.val, 1'b1});
        end else if (it.count == 32'd1) begin
            cmd_bytes_q.push_back('{slce_pkg::BYTE_WAIT_ONE, 1'b1});
        end else begin
            cmd_bytes_q.push_back('{slce_pkg::BYTE_WAIT_LONG, 1'b0});
            // A zero count wraps around here, as the hardware does.
            rest = it.count - slce_pkg::WAIT_BIAS;
            if (fmt_version == slce_pkg::VER_SHORT_WAIT) begin
                cmd_bytes_q.push_back('{rest[7:0], 1'b1});
            end else begin
                done = 1'b0;
                while (!done) begin
                    digit = rest[6:0] & slce_pkg::VARINT_MASK;
                    rest  = rest >> 7;
                    if (rest != '0) begin
                        cmd_bytes_q.push_back('{{1'b0, digit} | slce_pkg::VARINT_MORE, 1'b0});
                    end else begin
                        cmd_bytes_q.push_back('{{1'b0, digit}, 1'b1});
                        done = 1'b1;
                    end
                end
            end
        end
    endfunction

    // Random event; the fields that the kind ignores are random as well.
    function automatic t_log_item random_item();
        t_log_item   it;
        int unsigned sel;
        int unsigned ndig;
        logic [31:0] rnd;
        logic [slce_pkg::CountW-1:0] lo;
        logic [slce_pkg::CountW-1:0] hi;
        rnd = $urandom();
        it.kind = rnd[0];
        rnd = $urandom();
        it.part = rnd[slce_pkg::PartW-1:0];
        rnd = $urandom();
        it.addr = rnd[slce_pkg::ByteW-1:0];
        rnd = $urandom();
        it.val  = rnd[slce_pkg::ByteW-1:0];
        sel = $urandom_range(9, 0);
        if (sel == 0) begin
            it.count = 32'd1;
        end else if (sel == 1) begin
            it.count = $urandom_range(2, 0);
        end else if (sel < 7) begin
            // Aim at a given varint length, boundaries included.
            ndig = $urandom_range(4, 1);
            lo = (ndig == 1) ? 32'd0 : (32'd1 << (7 * (ndig - 1)));
            hi = (32'd1 << (7 * ndig)) - 32'd1;
            case ($urandom_range(3, 0))
                0: it.count = lo + slce_pkg::WAIT_BIAS;
                1: it.count = hi + slce_pkg::WAIT_BIAS;
                default: it.count = $urandom_range(hi, lo) + slce_pkg::WAIT_BIAS;
            endcase
        end else begin
            it.count = $urandom();
        end
        return it;
    endfunction

    task automatic add_write(input logic [slce_pkg::PartW-1:0] part,
                             input logic [slce_pkg::ByteW-1:0] addr,
                             input logic [slce_pkg::ByteW-1:0] val);
        t_log_item it;
        it = random_item();
        it.kind = slce_pkg::REQ_WRITE;
        it.part = part;
        it.addr = addr;
        it.val  = val;
        log_items_q.push_back(it);
    endtask

    task automatic add_wait(input logic [slce_pkg::CountW-1:0] count);
        t_log_item it;
        it = random_item();
        it.kind  = slce_pkg::REQ_WAIT;
        it.count = count;
        log_items_q.push_back(it);
    endtask

    task automatic add_random(input int unsigned n);
        repeat (n) log_items_q.push_back(random_item());
    endtask

    // Block until every event is sent and every byte has come back.
    task automatic drain();
        while (log_items_q.size() != 0 || s_axis_tvalid || cmd_bytes_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_version(input logic [slce_pkg::VerW-1:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        fmt_version = v;
    endtask

    // Sender: predicts on each transfer and then presents the next event.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
            send_quiet    <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                encode_command(sent_item);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap != 0) begin
                    s_axis_tvalid <= 1'b0;
                    send_gap      <= send_gap - 1;
                end else if (log_items_q.size() != 0) begin
                    sent_item = log_items_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= sent_item.kind;
                    s_axis_tdata  <= {1'b0, sent_item.count, sent_item.val,
                                      sent_item.addr, sent_item.part};
                    if (send_quiet != 0) begin
                        send_quiet <= send_quiet - 1;
                    end else if ($urandom_range(19, 0) == 0) begin
                        send_quiet <= $urandom_range(30, 10);
                    end else begin
                        send_gap <= pick_gap();
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each byte transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_cmd_byte want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_stall    <= 0;
            recv_quiet    <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (cmd_bytes_q.size() == 0) begin
                    $error("unexpected byte 0x%02h with no command pending", m_axis_tdata);
                    fail_cnt++;
                end else begin
                    want = cmd_bytes_q.pop_front();
                    if (m_axis_tdata !== want.data) begin
                        $error("out_byte: expected 0x%02h, got 0x%02h", want.data, m_axis_tdata);
                        fail_cnt++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                        fail_cnt++;
                    end
                end
            end
            if (recv_stall != 0) begin
                m_axis_tready <= 1'b0;
                recv_stall    <= recv_stall - 1;
            end else begin
                m_axis_tready <= 1'b1;
                if (recv_quiet != 0) begin
                    recv_quiet <= recv_quiet - 1;
                end else if ($urandom_range(39, 0) == 0) begin
                    recv_quiet <= $urandom_range(40, 10);
                end else if ($urandom_range(3, 0) == 0) begin
                    recv_stall <= pick_gap();
                end
            end
        end
    end

    // Stimulus phases: the reset version first, then one per format version written.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset version: register write extremes and every varint length.
        add_write(7'd0, 8'h00, 8'h00);
        add_write(7'd127, 8'hff, 8'hff);
        add_write(7'h2a, 8'h5a, 8'ha5);
        add_wait(32'd1);
        add_wait(32'd2);
        add_wait(32'd0);
        add_wait(32'd129);
        add_wait(32'd130);
        add_wait(32'd16385);
        add_wait(32'd16386);
        add_wait(32'd2097153);
        add_wait(32'd2097154);
        add_wait(32'd268435457);
        add_wait(32'd268435458);
        add_wait(32'hffffffff);
        add_random(30);
        drain();

        // Single-byte wait encoding, with truncation and wraparound.
        write_version(slce_pkg::VER_SHORT_WAIT);
        add_wait(32'd2);
        add_wait(32'd257);
        add_wait(32'd258);
        add_wait(32'd0);
        add_wait(32'd1);
        add_wait(32'hffffffff);
        add_write(7'd127, 8'h00, 8'hff);
        add_random(30);
        drain();

        write_version(2'd0);
        add_wait(32'd0);
        add_random(30);
        drain();

        write_version(2'd2);
        add_random(30);
        drain();

        write_version(2'd3);
        add_random(30);
        drain();

        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
